/* hw/rtl/array_list_insert_at_position_defines.svh */
// Assertion macros shared by the list checker.
`ifndef ARRAY_LIST_INSERT_AT_POSITION_DEFINES_SVH
`define ARRAY_LIST_INSERT_AT_POSITION_DEFINES_SVH

// Clocked assertion, off while reset is high.
`define ALIST_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked assertion, checked through reset as well.
`define ALIST_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* hw/rtl/alist_pkg.sv */
// Shared types, sizes and codes of the ordered record list.
package alist_pkg;

   localparam int LIST_DEPTH = 32;
   localparam int IDX_W      = $clog2(LIST_DEPTH);
   localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
   localparam int POS_W      = 8;
   localparam int CMP_W      = (POS_W > CNT_W) ? POS_W : CNT_W;
   localparam int NAME_W     = 64;
   localparam int AGE_W      = 8;
   localparam int OUT_IDX_W  = 5;
   localparam int OUT_CNT_W  = 6;

   localparam logic [1:0] CMD_CLEAR  = 2'd0;
   localparam logic [1:0] CMD_APPEND = 2'd1;
   localparam logic [1:0] CMD_INSERT = 2'd2;
   localparam logic [1:0] CMD_LIST   = 2'd3;

   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_ENTRY = 2'd2;
   localparam logic [1:0] STATUS_EMPTY = 2'd3;

   typedef struct packed {
      logic [NAME_W-1:0] name;
      logic [AGE_W-1:0]  age;
   } entry_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_ROTATE
   } cell_op_type;

   typedef struct packed {
      cell_op_type      op;
      logic [IDX_W-1:0] pos;
      logic [CNT_W-1:0] count;
   } cell_ctl_type;

endpackage

/* hw/rtl/alist_cell.sv */
// One list slot: holds a record and loads from a neighbor, the new record or the head.
module alist_cell (
   input  logic                              clock,
   input  alist_pkg::cell_ctl_type           ctl,
   input  logic [alist_pkg::IDX_W-1:0]       cell_index,
   input  alist_pkg::entry_type              left_entry,
   input  alist_pkg::entry_type              right_entry,
   input  alist_pkg::entry_type              head_entry,
   input  alist_pkg::entry_type              new_entry,
   output alist_pkg::entry_type              entry
);

   localparam int CntW = alist_pkg::CNT_W;

   alist_pkg::entry_type entry_ff;
   alist_pkg::entry_type entry_in;
   logic [CntW-1:0]      index_wide;

   assign index_wide = CntW'(cell_index);

   always_comb begin
      entry_in = entry_ff;
      case (ctl.op)
         alist_pkg::CELL_INSERT: begin
            if (cell_index == ctl.pos) begin
               entry_in = new_entry;
            end else if (cell_index > ctl.pos && index_wide <= ctl.count) begin
               entry_in = left_entry;
            end
         end
         alist_pkg::CELL_ROTATE: begin
            // wrap the head into the last occupied slot
            if (index_wide + CntW'(1) == ctl.count) begin
               entry_in = head_entry;
            end else if (index_wide + CntW'(1) < ctl.count) begin
               entry_in = right_entry;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

/* hw/rtl/alist_row.sv */
// Row of list cells wired to their neighbors; slot zero is the head.
module alist_row (
   input  logic                      clock,
   input  alist_pkg::cell_ctl_type   ctl,
   input  alist_pkg::entry_type      new_entry,
   output alist_pkg::entry_type      head_entry
);

   alist_pkg::entry_type entries [alist_pkg::LIST_DEPTH];

   for (genvar i = 0; i < alist_pkg::LIST_DEPTH; i++) begin : g_cell
      alist_pkg::entry_type left_entry;
      alist_pkg::entry_type right_entry;

      if (i == 0) begin : g_first
         assign left_entry = new_entry;
      end else begin : g_inner_left
         assign left_entry = entries[i-1];
      end

      if (i == alist_pkg::LIST_DEPTH - 1) begin : g_last
         assign right_entry = entries[0];
      end else begin : g_inner_right
         assign right_entry = entries[i+1];
      end

      alist_cell u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .cell_index  (alist_pkg::IDX_W'(i)),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .head_entry  (entries[0]),
         .new_entry   (new_entry),
         .entry       (entries[i])
      );
   end

   assign head_entry = entries[0];

endmodule

/* hw/rtl/array_list_insert_at_position.sv */
// Ordered record list: clear, append, insert at a position and list, on a row of cells.
//
// Requests enter on req_* (tuser = command, tdata = position, name, age); results
// leave on rsp_* (tuser = status, tlast = final result of the request).
// Clear, append and insert answer with one result. An insert loads every cell
// at once: the cells above the position take their lower neighbor, so the row
// is updated and the result is registered at the edge that takes the request.
// A full list drops the record and answers with the full status.
// List answers with one result per record, one per cycle while the receiver
// takes them: the row rotates by one slot per result and the head slot feeds
// the output, so after the last result the order is as before. It starts in the
// cycle after the request; an empty list gives one empty-status result.
// No request is taken while a list runs or while an unread result blocks the
// output register; a stalled receiver holds the result and the row.
// Reset empties the list (count zero) and drops any pending result; the
// record slots themselves are not cleared.
module array_list_insert_at_position (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,   // insert_position[7:0], name_word[71:8], age_value[79:72]
   input  logic [1:0]  req_tuser,   // cmd[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata,   // entry_index[4:0], entry_name[68:5], entry_age[76:69],
                                    // entry_count[82:77], zero[87:83]
   output logic [1:0]  rsp_tuser,   // status[1:0]
   output logic        rsp_tlast    // last_result
);

   localparam int IdxW    = alist_pkg::IDX_W;
   localparam int CntW    = alist_pkg::CNT_W;
   localparam int CmpW    = alist_pkg::CMP_W;
   localparam int OutIdxW = alist_pkg::OUT_IDX_W;
   localparam int OutCntW = alist_pkg::OUT_CNT_W;

   typedef enum logic {ST_IDLE, ST_LIST} state_type;

   state_type                     state_ff, state_in;
   logic [CntW-1:0]               count_ff, count_in;
   logic [IdxW-1:0]               list_idx_ff, list_idx_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [1:0]                    rsp_status_ff, rsp_status_in;
   logic [OutIdxW-1:0]            rsp_index_ff, rsp_index_in;
   logic [alist_pkg::NAME_W-1:0]  rsp_name_ff, rsp_name_in;
   logic [alist_pkg::AGE_W-1:0]   rsp_age_ff, rsp_age_in;
   logic [OutCntW-1:0]            rsp_count_ff, rsp_count_in;
   logic                          rsp_last_ff, rsp_last_in;

   logic                          out_free;
   logic                          accept;
   logic                          emit;
   logic                          list_last;
   logic                          full;
   logic [1:0]                    req_cmd;
   logic [alist_pkg::POS_W-1:0]   req_pos;
   logic [IdxW-1:0]               pos_eff;
   alist_pkg::entry_type          new_entry;
   alist_pkg::entry_type          head_entry;
   alist_pkg::cell_ctl_type       ctl;

   assign req_cmd        = req_tuser;
   assign req_pos        = req_tdata[7:0];
   assign new_entry.name = req_tdata[71:8];
   assign new_entry.age  = req_tdata[79:72];

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign accept     = req_tvalid && req_tready;
   assign emit       = (state_ff == ST_LIST) && out_free;
   assign full       = (count_ff == CntW'(alist_pkg::LIST_DEPTH));
   assign list_last  = (CntW'(list_idx_ff) + CntW'(1) == count_ff);

   always_comb begin
      if (req_cmd == alist_pkg::CMD_APPEND || CmpW'(req_pos) >= CmpW'(count_ff)) begin
         pos_eff = IdxW'(count_ff);
      end else begin
         pos_eff = IdxW'(req_pos);
      end
   end

   alist_row u_row (
      .clock      (clock),
      .ctl        (ctl),
      .new_entry  (new_entry),
      .head_entry (head_entry)
   );

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      list_idx_in   = list_idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_name_in   = rsp_name_ff;
      rsp_age_in    = rsp_age_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;
      ctl.op        = alist_pkg::CELL_HOLD;
      ctl.pos       = pos_eff;
      ctl.count     = count_ff;

      if (accept) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = alist_pkg::STATUS_DONE;
         rsp_index_in  = '0;
         rsp_name_in   = '0;
         rsp_age_in    = '0;
         rsp_last_in   = 1'b1;
         case (req_cmd)
            alist_pkg::CMD_CLEAR: begin
               count_in = '0;
            end
            alist_pkg::CMD_APPEND, alist_pkg::CMD_INSERT: begin
               if (full) begin
                  rsp_status_in = alist_pkg::STATUS_FULL;
               end else begin
                  ctl.op   = alist_pkg::CELL_INSERT;
                  count_in = count_ff + CntW'(1);
               end
            end
            alist_pkg::CMD_LIST: begin
               if (count_ff == '0) begin
                  rsp_status_in = alist_pkg::STATUS_EMPTY;
               end else begin
                  // results come from the head, one per cycle while the receiver takes them, in the list state
                  rsp_valid_in = 1'b0;
                  state_in     = ST_LIST;
                  list_idx_in  = '0;
               end
            end
            default: begin
               rsp_status_in = alist_pkg::STATUS_DONE;
            end
         endcase
         rsp_count_in = OutCntW'(count_in);
      end else if (emit) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = alist_pkg::STATUS_ENTRY;
         rsp_index_in  = OutIdxW'(list_idx_ff);
         rsp_name_in   = head_entry.name;
         rsp_age_in    = head_entry.age;
         rsp_count_in  = OutCntW'(count_ff);
         rsp_last_in   = list_last;
         ctl.op        = alist_pkg::CELL_ROTATE;
         list_idx_in   = list_idx_ff + IdxW'(1);
         if (list_last) begin
            state_in = ST_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         list_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         list_idx_ff   <= list_idx_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_status_ff <= rsp_status_in;
         rsp_index_ff  <= rsp_index_in;
         rsp_name_ff   <= rsp_name_in;
         rsp_age_ff    <= rsp_age_in;
         rsp_count_ff  <= rsp_count_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {5'd0, rsp_count_ff, rsp_age_ff, rsp_name_ff, rsp_index_ff};

endmodule

/* hw/rtl/alist_checker.sv */
// Port-level checks of the record list, bound to the top level.
`include "array_list_insert_at_position_defines.svh"

module alist_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [87:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);

   `ALIST_ASSERT(a_rsp_hold,
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast),
      "response changed while stalled")

   `ALIST_ASSERT(a_single_result,
      rsp_tvalid && rsp_tuser != alist_pkg::STATUS_ENTRY |-> rsp_tlast
         && rsp_tdata[76:0] == 77'd0,
      "non-entry result not last or not zeroed")

   `ALIST_ASSERT(a_empty_count,
      rsp_tvalid && rsp_tuser == alist_pkg::STATUS_EMPTY |-> rsp_tdata[82:77] == 6'd0,
      "empty status with nonzero count")

   `ALIST_ASSERT_ALWAYS(a_reset_quiet, $past(reset) |-> !rsp_tvalid, "response right after reset")

endmodule

bind array_list_insert_at_position alist_checker u_alist_checker (.*);
